// ----- rtl/core/qrv_pkg.sv -----
`timescale 1ns / 1ps

package qrv_pkg;

	localparam int DATA_W = 16;
	localparam int T_W    = 18;
	localparam int RND_SH = 15;

	typedef enum logic [1:0] {
		REG_ROT_X = 2'd0,
		REG_ROT_Y = 2'd1,
		REG_ROT_Z = 2'd2,
		REG_ROT_W = 2'd3
	} reg_idx_t;

	localparam logic signed [DATA_W-1:0] ROT_W_RESET = 16'sh7FFF;
	localparam logic signed [DATA_W-1:0] SAT_MAX     = 16'sh7FFF;
	localparam logic signed [DATA_W-1:0] SAT_MIN     = 16'sh8000;

	typedef struct packed {
		logic signed [DATA_W-1:0] vec_x;
		logic signed [DATA_W-1:0] vec_y;
		logic signed [DATA_W-1:0] vec_z;
	} vec_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_x;
		logic signed [DATA_W-1:0] out_y;
		logic signed [DATA_W-1:0] out_z;
		logic                     clipped;
	} res_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
		logic signed [DATA_W-1:0] w;
	} rot_t;

	// round to nearest (ties up) and drop 15 fraction bits; first product fits 18 bits
	function automatic logic signed [T_W-1:0] round_t(input logic signed [33:0] s);
		logic signed [34:0] a;
		a = {s[33], s} + 35'sd16384;
		return a[T_W+RND_SH-1:RND_SH];
	endfunction

	function automatic logic signed [22:0] round_r(input logic signed [36:0] s);
		logic signed [37:0] a;
		a = {s[36], s} + 38'sd16384;
		return a[37:RND_SH];
	endfunction

endpackage

// ----- rtl/core/qrv_pipe.sv -----
`timescale 1ns / 1ps

module qrv_pipe import qrv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  vec_t  vec,
	input  rot_t  rot,
	output logic  out_valid,
	output res_t  res
);

	// s1: products of q * v (w of v is zero)
	logic                valid_s1;
	logic signed [31:0]  p_s1 [12];
	// s2: t = round(q * v)
	logic                valid_s2;
	logic signed [T_W-1:0] t0_s2, t1_s2, t2_s2, t3_s2;
	// s3: products of t * conj(q)
	logic                valid_s3;
	logic signed [34:0]  m_s3 [12];
	// s4: rounded, saturated result
	logic                valid_s4;
	res_t                res_s4;

	logic signed [16:0]  c0, c1, c2, c3;
	logic signed [22:0]  r0, r1, r2;
	res_t                res_d;

	assign c0 = -{rot.x[15], rot.x};
	assign c1 = -{rot.y[15], rot.y};
	assign c2 = -{rot.z[15], rot.z};
	assign c3 = {rot.w[15], rot.w};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0]  <= rot.w * vec.vec_x;
			p_s1[1]  <= rot.y * vec.vec_z;
			p_s1[2]  <= rot.z * vec.vec_y;
			p_s1[3]  <= rot.w * vec.vec_y;
			p_s1[4]  <= rot.x * vec.vec_z;
			p_s1[5]  <= rot.z * vec.vec_x;
			p_s1[6]  <= rot.w * vec.vec_z;
			p_s1[7]  <= rot.x * vec.vec_y;
			p_s1[8]  <= rot.y * vec.vec_x;
			p_s1[9]  <= rot.x * vec.vec_x;
			p_s1[10] <= rot.y * vec.vec_y;
			p_s1[11] <= rot.z * vec.vec_z;

			t0_s2 <= round_t(34'(p_s1[0]) + 34'(p_s1[1]) - 34'(p_s1[2]));
			t1_s2 <= round_t(34'(p_s1[3]) - 34'(p_s1[4]) + 34'(p_s1[5]));
			t2_s2 <= round_t(34'(p_s1[6]) + 34'(p_s1[7]) - 34'(p_s1[8]));
			t3_s2 <= round_t(-34'(p_s1[9]) - 34'(p_s1[10]) - 34'(p_s1[11]));

			m_s3[0]  <= t3_s2 * c0;
			m_s3[1]  <= t0_s2 * c3;
			m_s3[2]  <= t1_s2 * c2;
			m_s3[3]  <= t2_s2 * c1;
			m_s3[4]  <= t3_s2 * c1;
			m_s3[5]  <= t0_s2 * c2;
			m_s3[6]  <= t1_s2 * c3;
			m_s3[7]  <= t2_s2 * c0;
			m_s3[8]  <= t3_s2 * c2;
			m_s3[9]  <= t0_s2 * c1;
			m_s3[10] <= t1_s2 * c0;
			m_s3[11] <= t2_s2 * c3;

			res_s4 <= res_d;
		end
	end

	always_comb begin
		r0 = round_r(37'(m_s3[0]) + 37'(m_s3[1]) + 37'(m_s3[2]) - 37'(m_s3[3]));
		r1 = round_r(37'(m_s3[4]) - 37'(m_s3[5]) + 37'(m_s3[6]) + 37'(m_s3[7]));
		r2 = round_r(37'(m_s3[8]) + 37'(m_s3[9]) - 37'(m_s3[10]) + 37'(m_s3[11]));
		res_d = '0;
		if (r0 > 23'(SAT_MAX)) begin
			res_d.out_x = SAT_MAX; res_d.clipped = 1'b1;
		end else if (r0 < 23'(SAT_MIN)) begin
			res_d.out_x = SAT_MIN; res_d.clipped = 1'b1;
		end else begin
			res_d.out_x = r0[15:0];
		end
		if (r1 > 23'(SAT_MAX)) begin
			res_d.out_y = SAT_MAX; res_d.clipped = 1'b1;
		end else if (r1 < 23'(SAT_MIN)) begin
			res_d.out_y = SAT_MIN; res_d.clipped = 1'b1;
		end else begin
			res_d.out_y = r1[15:0];
		end
		if (r2 > 23'(SAT_MAX)) begin
			res_d.out_z = SAT_MAX; res_d.clipped = 1'b1;
		end else if (r2 < 23'(SAT_MIN)) begin
			res_d.out_z = SAT_MIN; res_d.clipped = 1'b1;
		end else begin
			res_d.out_z = r2[15:0];
		end
	end

	assign out_valid = valid_s4;
	assign res       = res_s4;

endmodule

// ----- rtl/core/quaternion_rotate_vector.sv -----
`timescale 1ns / 1ps
// Rotates 3-D vectors by the quaternion q in rot_x/y/z/w: result = q * v * conj(q).
// Input channel: vec_valid / vec_stall / vec (vec_x, vec_y, vec_z, signed 16 bit).
// Output channel: res_valid / res_stall / res (out_x, out_y, out_z, clipped).
// An item moves when valid is high and stall is low at a rising clock edge.
// Config port: cfg_we with cfg_index (0 rot_x, 1 rot_y, 2 rot_z, 3 rot_w) and
// cfg_data; write only while no items are in flight.
// res_valid rises once an accepted item has passed the register stages, with no stall.
// Throughput: one item per cycle unless stalled; four register stages (two multiply
// stages, two sum/round stages), the last one being the output register.
// When res_stall is held against a valid result the whole pipeline freezes and
// vec_stall is raised in the same cycle; no item is dropped or repeated.
// Reset (arst_n low): pipeline emptied, q = identity (w = 32767, x = y = z = 0).
// Results are rounded to nearest and saturated to 16 bits; clipped flags it.

module quaternion_rotate_vector import qrv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vec_valid,
	output logic              vec_stall,
	input  vec_t              vec,
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	rot_t rot_q;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q.x <= '0;
			rot_q.y <= '0;
			rot_q.z <= '0;
			rot_q.w <= ROT_W_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ROT_X: rot_q.x <= cfg_data;
				REG_ROT_Y: rot_q.y <= cfg_data;
				REG_ROT_Z: rot_q.z <= cfg_data;
				REG_ROT_W: rot_q.w <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en        = !(res_valid && res_stall);
	assign vec_stall = !en;

	qrv_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vec_valid),
		.vec       (vec),
		.rot       (rot_q),
		.out_valid (res_valid),
		.res       (res)
	);

`ifndef SYNTHESIS
	a_clip_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.clipped |->
			res.out_x == SAT_MAX || res.out_x == SAT_MIN ||
			res.out_y == SAT_MAX || res.out_y == SAT_MIN ||
			res.out_z == SAT_MAX || res.out_z == SAT_MIN)
		else $error("clipped set with no saturated component");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(vec_valid && !vec_stall) ##1 en ##1 en ##1 en |=> res_valid)
		else $error("item did not reach output after four moving cycles");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(res_valid) |-> $past(!res_stall))
		else $error("result dropped while stalled");
`endif

endmodule

// ----- test/quaternion_rotate_vector_test.sv -----
`timescale 1ns / 1ps

module quaternion_rotate_vector_test;
	import qrv_pkg::*;

	typedef longint quat_t [4];
	typedef enum {RX_READY, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              vec_valid = 1'b0;
	logic              vec_stall;
	vec_t              vec       = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	res_t              res;
	logic              cfg_we    = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [DATA_W-1:0] cfg_data  = '0;

	rot_t     rot_model;
	res_t     rotated_q[$];
	int       n_sent    = 0;
	int       n_recv    = 0;
	int       n_bad     = 0;
	int       n_cfg     = 0;
	int       n_clipped = 0;
	int       burst_left = 0;
	int       gap_max   = 0;
	rx_mode_t rx_mode   = RX_READY;
	int       rx_pct    = 0;
	int       rx_period = 4;
	int       rx_busy   = 1;
	int       rx_cnt    = 0;
	int       hold_len  = 0;

	quaternion_rotate_vector i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.vec_valid (vec_valid),
		.vec_stall (vec_stall),
		.vec       (vec),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic longint round_q15(input longint s);
		return (s + 64'sd16384) >>> 15;
	endfunction

	function automatic quat_t hamilton_mul(input quat_t a, input quat_t b);
		quat_t r;
		r[0] = round_q15(a[3] * b[0] + a[0] * b[3] + a[1] * b[2] - a[2] * b[1]);
		r[1] = round_q15(a[3] * b[1] - a[0] * b[2] + a[1] * b[3] + a[2] * b[0]);
		r[2] = round_q15(a[3] * b[2] + a[0] * b[1] - a[1] * b[0] + a[2] * b[3]);
		r[3] = round_q15(a[3] * b[3] - a[0] * b[0] - a[1] * b[1] - a[2] * b[2]);
		return r;
	endfunction

	// q * v * conj(q), saturated to 16 bits
	function automatic res_t rotate_vec(input vec_t v);
		quat_t p, q, qc, t, r;
		res_t  o;
		p  = '{longint'(v.vec_x), longint'(v.vec_y), longint'(v.vec_z), 0};
		q  = '{longint'(rot_model.x), longint'(rot_model.y), longint'(rot_model.z),
			longint'(rot_model.w)};
		qc = '{-q[0], -q[1], -q[2], q[3]};
		t  = hamilton_mul(q, p);
		r  = hamilton_mul(t, qc);
		o.clipped = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (r[i] > longint'(SAT_MAX)) begin
				r[i] = longint'(SAT_MAX);
				o.clipped = 1'b1;
			end else if (r[i] < longint'(SAT_MIN)) begin
				r[i] = longint'(SAT_MIN);
				o.clipped = 1'b1;
			end
		end
		o.out_x = 16'(r[0]);
		o.out_y = 16'(r[1]);
		o.out_z = 16'(r[2]);
		return o;
	endfunction

	function automatic vec_t mk_vec(input int x, input int y, input int z);
		vec_t v;
		v.vec_x = 16'(x);
		v.vec_y = 16'(y);
		v.vec_z = 16'(z);
		return v;
	endfunction

	function automatic logic signed [15:0] edge16();
		case ($urandom_range(3))
			0: return SAT_MIN;
			1: return SAT_MAX;
			2: return 16'sd0;
			default: return -16'sd1;
		endcase
	endfunction

	function automatic vec_t rand_vec();
		vec_t v;
		case ($urandom_range(9))
			0: begin
				v.vec_x = edge16();
				v.vec_y = edge16();
				v.vec_z = edge16();
			end
			1, 2: v = mk_vec(int'($urandom_range(511)) - 256, int'($urandom_range(511)) - 256,
				int'($urandom_range(511)) - 256);
			default: v = vec_t'(48'({$urandom(), $urandom()}));
		endcase
		return v;
	endfunction

	// roughly unit length, so rotations rarely clip
	function automatic rot_t rand_unit_rot();
		real  a[4];
		real  n;
		rot_t q;
		do begin
			n = 0.0;
			for (int i = 0; i < 4; i++) begin
				a[i] = ($urandom_range(65535) - 32768.0) / 32768.0;
				n = n + a[i] * a[i];
			end
		end while (n < 0.01);
		n = $sqrt(n);
		q.x = 16'($rtoi(a[0] / n * 32767.0));
		q.y = 16'($rtoi(a[1] / n * 32767.0));
		q.z = 16'($rtoi(a[2] / n * 32767.0));
		q.w = 16'($rtoi(a[3] / n * 32767.0));
		return q;
	endfunction

	task automatic report(input string what, input res_t want, input res_t got);
		n_bad++;
		if (n_bad <= 10)
			$display("%t %s: expected x=%0d y=%0d z=%0d clip=%0b, got x=%0d y=%0d z=%0d clip=%0b",
				$realtime, what, want.out_x, want.out_y, want.out_z, want.clipped,
				got.out_x, got.out_y, got.out_z, got.clipped);
	endtask

	// result checker
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			n_recv++;
			if (res.clipped)
				n_clipped++;
			if (rotated_q.size() == 0) begin
				report("unexpected result", '0, res);
			end else begin
				want = rotated_q.pop_front();
				if (want.out_x !== res.out_x || want.out_y !== res.out_y ||
						want.out_z !== res.out_z || want.clipped !== res.clipped)
					report("result mismatch", want, res);
			end
		end
	end

	// output stall generator; a long hold takes priority
	initial begin
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				res_stall <= 1'b1;
				hold_len = hold_len - 1;
			end else begin
				case (rx_mode)
					RX_READY:   res_stall <= 1'b0;
					RX_RANDOM:  res_stall <= ($urandom_range(99) < rx_pct);
					RX_PATTERN: begin
						res_stall <= ((rx_cnt % rx_period) < rx_busy);
						rx_cnt++;
					end
					default:    res_stall <= 1'b0;
				endcase
			end
		end
	end

	task automatic set_traffic(input int gap, input rx_mode_t mode);
		gap_max   = gap;
		rx_mode   = mode;
		rx_pct    = $urandom_range(10, 70);
		rx_period = $urandom_range(2, 9);
		rx_busy   = $urandom_range(1, rx_period - 1);
	endtask

	// valid is left high across a burst; the caller sends again or drains in the same step
	task automatic send_vec(input vec_t v);
		vec_valid <= 1'b1;
		vec       <= v;
		do @(posedge clk); while (vec_stall);
		rotated_q.push_back(rotate_vec(v));
		n_sent++;
		if (gap_max > 0) begin
			if (burst_left == 0)
				burst_left = $urandom_range(1, 12);
			burst_left--;
			if (burst_left == 0) begin
				vec_valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		vec_valid <= 1'b0;
		burst_left = 0;
		while (rotated_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// block must be idle
	task automatic set_rotation(input rot_t q);
		reg_idx_t          idx;
		logic signed [15:0] val;
		for (int i = 0; i < 4; i++) begin
			idx = reg_idx_t'(i);
			case (idx)
				REG_ROT_X: val = q.x;
				REG_ROT_Y: val = q.y;
				REG_ROT_Z: val = q.z;
				REG_ROT_W: val = q.w;
				default:   val = q.w;
			endcase
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= val;
			@(posedge clk);
			case (idx)
				REG_ROT_X: rot_model.x = val;
				REG_ROT_Y: rot_model.y = val;
				REG_ROT_Z: rot_model.z = val;
				REG_ROT_W: rot_model.w = val;
				default: ;
			endcase
			n_cfg++;
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		set_traffic(0, RX_READY);
		// identity after reset
		send_vec(mk_vec(32767, 32767, 32767));
		send_vec(mk_vec(-32768, -32768, -32768));
		send_vec(mk_vec(0, 0, 0));
		send_vec(mk_vec(1, -1, 0));
		send_vec(mk_vec(-32768, 32767, 0));
		send_vec(mk_vec(12345, -23456, 7));
		send_vec(mk_vec(-1, -1, -1));
		send_vec(mk_vec(16384, -16384, 32767));
		wait_drained();
		// quarter turn about z
		set_rotation('{x: 16'sd0, y: 16'sd0, z: 16'sd23170, w: 16'sd23170});
		send_vec(mk_vec(32767, 0, 0));
		send_vec(mk_vec(-32768, 32767, -32768));
		send_vec(mk_vec(100, 200, 300));
		wait_drained();
		// most negative components, non-unit: heavy clipping
		set_rotation('{x: SAT_MIN, y: SAT_MIN, z: SAT_MIN, w: SAT_MIN});
		send_vec(mk_vec(-32768, -32768, -32768));
		send_vec(mk_vec(32767, -32768, 1));
		send_vec(mk_vec(3, 2, 1));
		wait_drained();
		set_rotation('{x: SAT_MAX, y: SAT_MAX, z: SAT_MAX, w: SAT_MAX});
		send_vec(mk_vec(32767, 32767, 32767));
		send_vec(mk_vec(-32768, 0, 32767));
		send_vec(mk_vec(-5, 9, -13));
		wait_drained();
		// half turn about x
		set_rotation('{x: SAT_MAX, y: 16'sd0, z: 16'sd0, w: 16'sd0});
		send_vec(mk_vec(1000, -2000, 3000));
		send_vec(mk_vec(-32768, -32768, 32767));
		wait_drained();
		set_rotation('{x: 16'sd0, y: 16'sd0, z: 16'sd0, w: 16'sd0});
		send_vec(mk_vec(32767, -32768, 32767));
		send_vec(mk_vec(-1, 1, -1));
		wait_drained();
	endtask

	task automatic test_random_unit();
		for (int ph = 0; ph < 4; ph++) begin
			set_rotation(rand_unit_rot());
			set_traffic(ph == 0 ? 0 : $urandom_range(1, 10), rx_mode_t'(ph % 3));
			repeat (100)
				send_vec(rand_vec());
			wait_drained();
		end
	endtask

	task automatic test_random_raw();
		for (int ph = 0; ph < 2; ph++) begin
			set_rotation(rot_t'({$urandom(), $urandom()}));
			set_traffic($urandom_range(0, 6), ph ? RX_PATTERN : RX_RANDOM);
			repeat (60)
				send_vec(rand_vec());
			wait_drained();
		end
	endtask

	// output held off for a long stretch while input keeps coming
	task automatic test_backpressure();
		set_rotation(rand_unit_rot());
		set_traffic(0, RX_READY);
		hold_len = 150;
		repeat (60)
			send_vec(rand_vec());
		wait_drained();
	endtask

	// sender pauses until every result is back, then resumes
	task automatic test_sender_pause();
		set_rotation(rand_unit_rot());
		for (int k = 0; k < 3; k++) begin
			set_traffic($urandom_range(0, 4), RX_RANDOM);
			repeat (20)
				send_vec(rand_vec());
			wait_drained();
		end
	endtask

	initial begin
		rot_model = '{x: 16'sd0, y: 16'sd0, z: 16'sd0, w: ROT_W_RESET};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_unit();
		test_random_raw();
		test_backpressure();
		test_sender_pause();
		wait_drained();
		n_bad += rotated_q.size();
		$display("%0d vectors rotated, %0d results checked, %0d of them clipped, %0d register writes",
			n_sent, n_recv, n_clipped, n_cfg);
		$display("traffic: bursts with gaps, random and periodic output stalls, long output hold");
		if (n_bad == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/qrv_pkg.sv
rtl/core/qrv_pipe.sv
rtl/core/quaternion_rotate_vector.sv
test/quaternion_rotate_vector_test.sv
